// ===== src/rqps_pkg.sv =====
package rqps_pkg;

  // Default number of entries held by the ready queue.
  localparam int RQPS_DEPTH = 32;

  // Field widths of one queue entry.
  localparam int ID_W      = 16;
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int ARRIVAL_W = 16;
  localparam int ENTRY_W   = ID_W + BURST_W + PRIO_W + ARRIVAL_W;
  localparam int KEY_W     = 16;
  localparam int OCC_W     = 6;

  // Extraction policy codes.
  localparam logic [1:0] POL_OLDEST = 2'd0;
  localparam logic [1:0] POL_BURST  = 2'd1;
  localparam logic [1:0] POL_PRIO   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Command codes.
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // One stored process entry, packed as it sits in the memory.
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    logic [ID_W-1:0]      id;
  } entry_t;

  // Value compared under the given policy; zero for every entry when oldest first.
  function automatic logic [KEY_W-1:0] sort_key(input logic [1:0] pol, input entry_t e);
    logic [KEY_W-1:0] k;
    case (pol)
      POL_BURST: k = e.burst;
      POL_PRIO:  k = KEY_W'(e.prio);
      default:   k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== src/rqps_ram.sv =====
module rqps_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 56,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ready_queue_policy_select.sv =====
// Ready queue with a selectable extraction policy.
//
// A command is transferred at a rising edge where start is high and busy is
// low. in_action selects an insert at the tail or an extract by the policy
// held in the configuration register (written with cfg_wr_en / cfg_wr_data,
// 0 oldest first, 1 smallest burst, 2 smallest priority number).
// Every command gives one result, shown on the out_ ports for exactly one
// cycle with out_strobe high. The receiver cannot stall, so the result must
// be taken in that cycle.
// An insert, or an extract on an empty queue, gives its result in the cycle
// after the transfer. An extract scans the stored entries through the single
// memory read port, then closes the gap behind the removed entry one entry
// per cycle before its result is shown. busy stays high throughout, and the
// next command may be transferred in the cycle that shows the result.
// Reset empties the queue and sets the policy to oldest first; the entry
// memory itself is not cleared, so no clearing pass is needed.
module ready_queue_policy_select
  import rqps_pkg::*;
#(
  parameter int QUEUE_DEPTH = RQPS_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_action,
  input  logic [ID_W-1:0]      in_proc_id,
  input  logic [BURST_W-1:0]   in_burst_len,
  input  logic [PRIO_W-1:0]    in_prio_level,
  input  logic [ARRIVAL_W-1:0] in_arrival_time,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic                 out_valid,
  output logic [ID_W-1:0]      out_proc_id,
  output logic [BURST_W-1:0]   out_burst,
  output logic [PRIO_W-1:0]    out_prio,
  output logic [ARRIVAL_W-1:0] out_arrival,
  output logic [OCC_W-1:0]     out_occupancy
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT
  } state_t;

  state_t           state_r;
  logic [1:0]       policy_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    cmp_idx_r;
  logic [CW-1:0]    rd_idx_r;
  logic [AW-1:0]    wr_idx_r;
  logic [AW-1:0]    best_idx_r;
  logic [KEY_W-1:0] best_key_r;
  entry_t           best_entry_r;

  logic             out_strobe_r;
  logic [1:0]       out_status_r;
  logic             out_valid_r;
  entry_t           out_entry_r;
  logic [OCC_W-1:0] out_occupancy_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t           rd_entry;
  entry_t           in_entry;
  logic [KEY_W-1:0] rd_key;
  logic             accept;
  logic [CW-1:0]    best_next;

  assign accept    = start && (state_r == S_IDLE);
  assign rd_entry  = entry_t'(mem_rdata);
  assign rd_key    = sort_key(policy_r, rd_entry);
  assign best_next = CW'(best_idx_r) + CW'(1);

  always_comb begin
    in_entry.id      = in_proc_id;
    in_entry.burst   = in_burst_len;
    in_entry.prio    = in_prio_level;
    in_entry.arrival = in_arrival_time;
  end

  // Memory port control: tail writes on insert, one read per cycle while scanning
  // and shifting, and the gap closed by writing each entry one slot lower.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = in_entry;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_action == ACT_INSERT && count_r < DEPTH_C) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
        end
        if (accept && in_action == ACT_EXTRACT && count_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      S_SCAN: begin
        mem_re    = rd_idx_r < count_r;
        mem_raddr = rd_idx_r[AW-1:0];
      end
      S_SHIFT_START: begin
        mem_re    = best_next < count_r;
        mem_raddr = best_next[AW-1:0];
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx_r;
        mem_wdata = rd_entry;
        mem_re    = rd_idx_r < count_r;
        mem_raddr = rd_idx_r[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  rqps_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequencer, queue count, policy register and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      policy_r     <= POL_OLDEST;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_action == ACT_INSERT) begin
              out_strobe_r <= 1'b1;
              out_valid_r  <= 1'b0;
              out_entry_r  <= '0;
              if (count_r < DEPTH_C) begin
                out_status_r    <= ST_OK;
                count_r         <= count_r + CW'(1);
                out_occupancy_r <= OCC_W'(count_r + CW'(1));
              end else begin
                out_status_r    <= ST_FULL;
                out_occupancy_r <= OCC_W'(count_r);
              end
            end else if (count_r == '0) begin
              out_strobe_r    <= 1'b1;
              out_valid_r     <= 1'b0;
              out_entry_r     <= '0;
              out_status_r    <= ST_EMPTY;
              out_occupancy_r <= OCC_W'(count_r);
            end else begin
              cmp_idx_r <= '0;
              rd_idx_r  <= CW'(1);
              state_r   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Strict less-than keeps the oldest entry on a tie.
          if (cmp_idx_r == '0 || rd_key < best_key_r) begin
            best_idx_r   <= cmp_idx_r[AW-1:0];
            best_key_r   <= rd_key;
            best_entry_r <= rd_entry;
          end
          cmp_idx_r <= cmp_idx_r + CW'(1);
          rd_idx_r  <= rd_idx_r + CW'(1);
          if (cmp_idx_r == count_r - CW'(1)) begin
            state_r <= S_SHIFT_START;
          end
        end
        S_SHIFT_START: begin
          if (best_next < count_r) begin
            rd_idx_r <= best_next + CW'(1);
            wr_idx_r <= best_idx_r;
            state_r  <= S_SHIFT;
          end else begin
            count_r         <= count_r - CW'(1);
            out_strobe_r    <= 1'b1;
            out_valid_r     <= 1'b1;
            out_status_r    <= ST_OK;
            out_entry_r     <= best_entry_r;
            out_occupancy_r <= OCC_W'(count_r - CW'(1));
            state_r         <= S_IDLE;
          end
        end
        S_SHIFT: begin
          rd_idx_r <= rd_idx_r + CW'(1);
          wr_idx_r <= wr_idx_r + AW'(1);
          // The last write lands in the slot just below the old tail.
          if (CW'(wr_idx_r) == count_r - CW'(2)) begin
            count_r         <= count_r - CW'(1);
            out_strobe_r    <= 1'b1;
            out_valid_r     <= 1'b1;
            out_status_r    <= ST_OK;
            out_entry_r     <= best_entry_r;
            out_occupancy_r <= OCC_W'(count_r - CW'(1));
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_valid     = out_valid_r;
  assign out_proc_id   = out_entry_r.id;
  assign out_burst     = out_entry_r.burst;
  assign out_prio      = out_entry_r.prio;
  assign out_arrival   = out_entry_r.arrival;
  assign out_occupancy = out_occupancy_r;

endmodule

// ===== sim/ready_queue_policy_monitor.sv =====
`timescale 1ns / 1ps

// Watches the command, result and configuration ports of the ready queue,
// keeps a shadow copy of the queue and checks every result in order.
module ready_queue_policy_monitor
  import rqps_pkg::*;
#(
  parameter int DEPTH = RQPS_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_action,
  input  logic [ID_W-1:0]      in_proc_id,
  input  logic [BURST_W-1:0]   in_burst_len,
  input  logic [PRIO_W-1:0]    in_prio_level,
  input  logic [ARRIVAL_W-1:0] in_arrival_time,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data,
  input  logic                 out_strobe,
  input  logic [1:0]           out_status,
  input  logic                 out_valid,
  input  logic [ID_W-1:0]      out_proc_id,
  input  logic [BURST_W-1:0]   out_burst,
  input  logic [PRIO_W-1:0]    out_prio,
  input  logic [ARRIVAL_W-1:0] out_arrival,
  input  logic [OCC_W-1:0]     out_occupancy,
  output int                   fail_count,
  output int                   pending,
  output int                   full_hits,
  output int                   empty_hits
);

  // One predicted result, field by field.
  typedef struct packed {
    logic [1:0]           status;
    logic                 valid;
    logic [ID_W-1:0]      id;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
    logic [ARRIVAL_W-1:0] arrival;
    logic [OCC_W-1:0]     occ;
  } outcome_t;

  entry_t     shadow_entries[$];
  outcome_t   expected_outcomes[$];
  logic [1:0] shadow_policy;

  // Ranking value of an entry under the shadow policy; lower is picked first.
  function automatic int unsigned rank_of(input entry_t e);
    if (shadow_policy == POL_BURST) return 32'(e.burst);
    if (shadow_policy == POL_PRIO) return 32'(e.prio);
    return 0;
  endfunction

  // Applies one command to the shadow queue and returns the result it gives.
  function automatic outcome_t schedule_command(input logic act, input entry_t fresh);
    outcome_t o;
    int       pick;
    o = '0;
    o.status = ST_OK;
    if (act == ACT_INSERT) begin
      if (shadow_entries.size() >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        shadow_entries.push_back(fresh);
      end
    end else if (shadow_entries.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // Strict comparison keeps the oldest entry on a tie.
      pick = 0;
      for (int i = 1; i < shadow_entries.size(); i++) begin
        if (rank_of(shadow_entries[i]) < rank_of(shadow_entries[pick])) pick = i;
      end
      o.valid   = 1'b1;
      o.id      = shadow_entries[pick].id;
      o.burst   = shadow_entries[pick].burst;
      o.prio    = shadow_entries[pick].prio;
      o.arrival = shadow_entries[pick].arrival;
      shadow_entries.delete(pick);
    end
    o.occ = OCC_W'(shadow_entries.size());
    return o;
  endfunction

  // Compares one field and counts a mismatch.
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Results are checked before a new transfer in the same cycle is predicted,
  // since a result always belongs to an earlier command.
  always @(posedge clk) begin
    outcome_t want;
    entry_t   fresh;
    if (!rst_n) begin
      shadow_entries.delete();
      expected_outcomes.delete();
      shadow_policy = POL_OLDEST;
    end else begin
      if (out_strobe) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with status %0d arrived with no command outstanding", out_status);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          compare_field("out_status", 32'(want.status), 32'(out_status));
          compare_field("out_valid", 32'(want.valid), 32'(out_valid));
          compare_field("out_proc_id", 32'(want.id), 32'(out_proc_id));
          compare_field("out_burst", 32'(want.burst), 32'(out_burst));
          compare_field("out_prio", 32'(want.prio), 32'(out_prio));
          compare_field("out_arrival", 32'(want.arrival), 32'(out_arrival));
          compare_field("out_occupancy", 32'(want.occ), 32'(out_occupancy));
        end
      end
      if (cfg_wr_en) shadow_policy = cfg_wr_data;
      if (start && !busy) begin
        fresh.id      = in_proc_id;
        fresh.burst   = in_burst_len;
        fresh.prio    = in_prio_level;
        fresh.arrival = in_arrival_time;
        want = schedule_command(in_action, fresh);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
        expected_outcomes.push_back(want);
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

// ===== sim/ready_queue_policy_select_test.sv =====
`timescale 1ns / 1ps

module ready_queue_policy_select_test;
  import rqps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 2 * RQPS_DEPTH + 16;
  localparam int RANDOM_ITEMS = 550;

  // Policy code with no meaning of its own; the block treats it as oldest first.
  localparam logic [1:0] POL_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_action;
  logic [ID_W-1:0]      in_proc_id;
  logic [BURST_W-1:0]   in_burst_len;
  logic [PRIO_W-1:0]    in_prio_level;
  logic [ARRIVAL_W-1:0] in_arrival_time;
  logic                 cfg_wr_en;
  logic [1:0]           cfg_wr_data;
  logic                 out_strobe;
  logic [1:0]           out_status;
  logic                 out_valid;
  logic [ID_W-1:0]      out_proc_id;
  logic [BURST_W-1:0]   out_burst;
  logic [PRIO_W-1:0]    out_prio;
  logic [ARRIVAL_W-1:0] out_arrival;
  logic [OCC_W-1:0]     out_occupancy;

  int   fail_count;
  int   pending;
  int   full_hits;
  int   empty_hits;
  int   cycle_count;
  int   inserts_sent;
  int   extracts_sent;
  int   phases_run;
  logic handed_off;

  ready_queue_policy_select u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_proc_id     (in_proc_id),
    .in_burst_len   (in_burst_len),
    .in_prio_level  (in_prio_level),
    .in_arrival_time(in_arrival_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_valid      (out_valid),
    .out_proc_id    (out_proc_id),
    .out_burst      (out_burst),
    .out_prio       (out_prio),
    .out_arrival    (out_arrival),
    .out_occupancy  (out_occupancy)
  );

  ready_queue_policy_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_proc_id     (in_proc_id),
    .in_burst_len   (in_burst_len),
    .in_prio_level  (in_prio_level),
    .in_arrival_time(in_arrival_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_valid      (out_valid),
    .out_proc_id    (out_proc_id),
    .out_burst      (out_burst),
    .out_prio       (out_prio),
    .out_arrival    (out_arrival),
    .out_occupancy  (out_occupancy),
    .fail_count     (fail_count),
    .pending        (pending),
    .full_hits      (full_hits),
    .empty_hits     (empty_hits)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Flags the command transfer that took place at the last rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      handed_off <= 1'b0;
    end else begin
      handed_off <= start && !busy;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Presents one command after an optional gap and holds it until transfer.
  task automatic issue(input logic act, input logic [ID_W-1:0] id,
                       input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                       input logic [ARRIVAL_W-1:0] arrival, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           = 1'b1;
    in_action       = act;
    in_proc_id      = id;
    in_burst_len    = burst;
    in_prio_level   = prio;
    in_arrival_time = arrival;
    do @(negedge clk); while (handed_off !== 1'b1);
    if (act == ACT_INSERT) inserts_sent++;
    else extracts_sent++;
  endtask

  // Stops sending and waits until every outstanding result has been seen.
  task automatic wait_for_quiet();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Writes the policy register while the queue is idle.
  task automatic set_policy(input logic [1:0] pol);
    wait_for_quiet();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = pol;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Draws a 16-bit key biased toward small values so that ties are common.
  function automatic logic [15:0] draw_key16();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom_range(0, 7));
    if (sel == 5) return 16'h0000;
    if (sel == 6) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Same for the 8-bit priority number.
  function automatic logic [7:0] draw_key8();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 8'($urandom_range(0, 7));
    if (sel == 5) return 8'h00;
    if (sel == 6) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int   phase_len;
    int   insert_pct;
    int   gap;
    int   random_sent;
    logic no_idle;
    logic act;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_INSERT;
    in_proc_id      = '0;
    in_burst_len    = '0;
    in_prio_level   = '0;
    in_arrival_time = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = POL_OLDEST;
    inserts_sent    = 0;
    extracts_sent   = 0;
    phases_run      = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, oldest first from reset: empty extract, field extremes,
    // then a tie on burst and priority.
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 0);
    issue(ACT_INSERT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_INSERT, 16'h0001, 16'h0005, 8'h03, 16'h0007, 1);
    issue(ACT_INSERT, 16'h0002, 16'h0005, 8'h03, 16'h0008, 0);
    issue(ACT_EXTRACT, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 0);

    // Smallest burst, then the older of two equal bursts.
    set_policy(POL_BURST);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 2);

    // Smallest priority number.
    set_policy(POL_PRIO);
    issue(ACT_INSERT, 16'h0003, 16'h0009, 8'h00, 16'h0009, 0);
    issue(ACT_INSERT, 16'h0004, 16'h0001, 8'h00, 16'h000A, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);

    // The unused policy code falls back to oldest first.
    set_policy(POL_UNUSED);
    issue(ACT_INSERT, 16'h0005, 16'h0000, 8'h00, 16'h0005, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);
    issue(ACT_EXTRACT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 0);

    // Random phases: each picks a policy and a fill, drain or balanced mix, so
    // the queue swings between empty and full under every policy.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_policy(2'($urandom_range(0, 3)));
      phases_run++;
      phase_len = $urandom_range(20, 60);
      if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        issue(act, 16'($urandom_range(0, 65535)), draw_key16(), draw_key8(),
              16'($urandom_range(0, 65535)), gap);
        random_sent++;
      end
    end

    // Let every result come back, then a quiet tail for stray strobes.
    wait_for_quiet();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d inserts and %0d extracts over %0d random policy phases.",
             inserts_sent, extracts_sent, phases_run);
    $display("Saw %0d inserts on a full queue and %0d extracts on an empty one.",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rqps_pkg.sv
src/rqps_ram.sv
src/ready_queue_policy_select.sv
sim/ready_queue_policy_monitor.sv
sim/ready_queue_policy_select_test.sv
